/* design/assert_macros.svh */
// assertion macros shared by the checker files
// no dependencies; clock and reset are the names used on the block ports
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on the block clock, off while reset is high
`define B2D_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("b2d port check failed");

// same check, also evaluated while reset is high
`define B2D_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("b2d port check failed");

`endif

/* design/b2d_pkg.sv */
// shared constants and types for the binary to decimal ascii converter
// no dependencies
package b2d_pkg;

   localparam int VALUE_WIDTH = 64;
   localparam int MAX_DIGITS  = 20;
   localparam int DIGIT_W     = 4;
   localparam int ASCII_W     = 6;
   localparam logic [ASCII_W-1:0] ASCII_ZERO = 6'd48;

   // one down counter serves both the shift phase and the digit phase
   localparam int CNT_MAX = (VALUE_WIDTH > MAX_DIGITS) ? VALUE_WIDTH : MAX_DIGITS;
   localparam int CNT_W   = $clog2(CNT_MAX);

   typedef logic [DIGIT_W-1:0] digit_type;

   typedef struct packed {
      logic load;    // take a new value, clear the digits
      logic dabble;  // one add-3 and shift step
      logic unload;  // move digits up by one place
   } ctrl_type;

endpackage

/* design/b2d_dabble.sv */
// binary shift register and bcd digit register for bit-serial double dabble
// depends on b2d_pkg
module b2d_dabble (
   input  logic                              clock,
   input  b2d_pkg::ctrl_type                 ctrl,
   input  logic [b2d_pkg::VALUE_WIDTH-1:0]   load_value,
   output b2d_pkg::digit_type                top_digit
);
   import b2d_pkg::*;

   logic [VALUE_WIDTH-1:0] shift_ff, shift_in;
   digit_type              digits_ff [MAX_DIGITS];
   digit_type              digits_in [MAX_DIGITS];
   digit_type              adj       [MAX_DIGITS];

   // add 3 to every digit of 5 or more
   always_comb begin
      for (int i = 0; i < MAX_DIGITS; i++) begin
         adj[i] = (digits_ff[i] >= 4'd5) ? digits_ff[i] + 4'd3 : digits_ff[i];
      end
   end

   // load, dabble and unload never come together; with none of them the registers hold
   always_comb begin
      shift_in = shift_ff;
      for (int i = 0; i < MAX_DIGITS; i++) begin
         digits_in[i] = digits_ff[i];
      end
      if (ctrl.load) begin
         shift_in = load_value;
         for (int i = 0; i < MAX_DIGITS; i++) begin
            digits_in[i] = '0;
         end
      end else if (ctrl.dabble) begin
         shift_in = {shift_ff[VALUE_WIDTH-2:0], 1'b0};
         digits_in[0] = {adj[0][DIGIT_W-2:0], shift_ff[VALUE_WIDTH-1]};
         for (int i = 1; i < MAX_DIGITS; i++) begin
            digits_in[i] = {adj[i][DIGIT_W-2:0], adj[i-1][DIGIT_W-1]};
         end
      end else if (ctrl.unload) begin
         digits_in[0] = '0;
         for (int i = 1; i < MAX_DIGITS; i++) begin
            digits_in[i] = digits_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      for (int i = 0; i < MAX_DIGITS; i++) begin
         digits_ff[i] <= digits_in[i];
      end
   end

   assign top_digit = digits_ff[MAX_DIGITS-1];

endmodule

/* design/b2d_emit.sv */
// leading zero suppression and ascii output register
// depends on b2d_pkg
module b2d_emit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           clear,
   input  logic                           enable,
   input  logic                           units,
   input  b2d_pkg::digit_type             digit,
   output logic                           strobe,
   output logic [b2d_pkg::ASCII_W-1:0]    ascii,
   output logic                           last
);
   import b2d_pkg::*;

   logic               started_ff, started_in;
   logic               strobe_ff, strobe_in;
   logic [ASCII_W-1:0] ascii_ff, ascii_in;
   logic               last_ff, last_in;

   // the units digit always goes out, so zero gives a single '0'
   always_comb begin
      strobe_in  = enable && (started_ff || (digit != '0) || units);
      started_in = clear ? 1'b0 : (started_ff || strobe_in);
      ascii_in   = ASCII_ZERO + {{(ASCII_W-DIGIT_W){1'b0}}, digit};
      last_in    = units;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
         strobe_ff  <= 1'b0;
      end else begin
         started_ff <= started_in;
         strobe_ff  <= strobe_in;
      end
      ascii_ff <= ascii_in;
      last_ff  <= last_in;
   end

   assign strobe = strobe_ff;
   assign ascii  = ascii_ff;
   assign last   = last_ff;

endmodule

/* design/binary_to_decimal_ascii_top.sv */
// top level of the binary to decimal ascii converter
// depends on b2d_pkg, b2d_dabble and b2d_emit
//
// usage
//  - command port: drive req_value and raise start; the beat is taken at a
//    rising edge where start is high and busy is low, then busy stays high
//    until the digit phase is over
//  - result port: one beat per decimal digit, most significant first, no
//    leading zeros; rsp_strobe marks each beat for one cycle and
//    rsp_last_digit flags the units digit; zero gives one '0' beat
//  - the receiver cannot hold results off; beats come on consecutive cycles
//  - sequence: a shift phase (one value bit per cycle through the bcd digit
//    register), then a digit phase that scans the digit register from the
//    top; each digit beat is registered on its way out
//  - a new command is taken only once the bit-serial shift loop and the
//    digit scan are over; the next command may be taken in the cycle
//    that shows the last digit
//  - reset clears the sequencer and the output strobe; no beat is in flight
//    after reset
module binary_to_decimal_ascii_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [63:0]                       req_value,
   output logic                              rsp_strobe,
   output logic [b2d_pkg::ASCII_W-1:0]       rsp_ascii_digit,
   output logic                              rsp_last_digit
);
   import b2d_pkg::*;

   // sequencer states
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CONV = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             accept;
   logic             cnt_zero;
   ctrl_type         ctrl;
   digit_type        top_digit;

   assign accept   = start && (state_ff == ST_IDLE);
   assign cnt_zero = (cnt_ff == '0);
   assign busy     = (state_ff != ST_IDLE);

   // the counter counts down the shift steps, then the digits; zero marks the last of each
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_CONV;
               cnt_in   = CNT_W'(VALUE_WIDTH - 1);
            end
         end
         ST_CONV: begin
            if (cnt_zero) begin
               state_in = ST_EMIT;
               cnt_in   = CNT_W'(MAX_DIGITS - 1);
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_EMIT: begin
            if (cnt_zero) begin
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      ctrl.load   = accept;
      ctrl.dabble = (state_ff == ST_CONV);
      ctrl.unload = (state_ff == ST_EMIT);
   end

   // bits above the value width are dropped at load
   b2d_dabble u_dabble (
      .clock      (clock),
      .ctrl       (ctrl),
      .load_value (req_value[VALUE_WIDTH-1:0]),
      .top_digit  (top_digit)
   );

   // the digit at the top of the register goes out while it is scanned
   b2d_emit u_emit (
      .clock  (clock),
      .reset  (reset),
      .clear  (accept),
      .enable (ctrl.unload),
      .units  (cnt_zero),
      .digit  (top_digit),
      .strobe (rsp_strobe),
      .ascii  (rsp_ascii_digit),
      .last   (rsp_last_digit)
   );

endmodule

/* design/b2d_checker.sv */
// port level checks for the binary to decimal ascii converter
// depends on b2d_pkg and assert_macros.svh; bound to the top level below
`include "assert_macros.svh"

module b2d_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           start,
   input logic                           busy,
   input logic [63:0]                    req_value,
   input logic                           rsp_strobe,
   input logic [b2d_pkg::ASCII_W-1:0]    rsp_ascii_digit,
   input logic                           rsp_last_digit
);
   import b2d_pkg::*;

   localparam logic [ASCII_W-1:0] ASCII_NINE = ASCII_ZERO + 6'd9;

   logic unused_value;
   assign unused_value = ^req_value;

   // a taken command keeps the block busy
   `B2D_ASSERT(a_cmd_busy, (start && !busy) |=> busy)
   // every beat carries a decimal digit character
   `B2D_ASSERT(a_ascii_range, rsp_strobe |-> (rsp_ascii_digit >= ASCII_ZERO) && (rsp_ascii_digit <= ASCII_NINE))
   // digits of one number come without gaps
   `B2D_ASSERT(a_no_gap, (rsp_strobe && !rsp_last_digit) |=> rsp_strobe)
   // the end of the busy period shows the units digit
   `B2D_ASSERT(a_done_last, $fell(busy) |-> (rsp_strobe && rsp_last_digit))
   // nothing comes out of reset
   `B2D_ASSERT_ALWAYS(a_reset_quiet, reset |=> !rsp_strobe && !busy)

endmodule

bind binary_to_decimal_ascii_top b2d_checker u_b2d_checker (.*);

/* tb/tb_top.sv */
// self-checking bench for binary_to_decimal_ascii_top: 64-bit values in, ascii digits out
// uses b2d_pkg for the digit and ascii widths; expected digits come from a divide-by-ten predictor or typed-in strings
module tb_top;
   import b2d_pkg::*;

   // run length and limits
   localparam int RANDOM_BEATS = 360;
   localparam int QUIET_TAIL   = 60;      // final command beats sent with no gaps
   localparam int PAUSE_AT     = 150;     // drain all digits once mid-run
   localparam int DRAIN_CYCLES = 100;     // a bit more than one conversion
   localparam int CYCLE_LIMIT  = 200000;  // ~380 beats at a full conversion each, several times over
   localparam int DIR_N        = 20;

   // one expected digit beat
   typedef struct packed {
      logic [ASCII_W-1:0] ascii;
      logic               is_last;
   } digit_beat_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                start;
   logic                busy;
   logic [63:0]         req_value;
   logic                rsp_strobe;
   logic [ASCII_W-1:0]  rsp_ascii_digit;
   logic                rsp_last_digit;

   digit_beat_type pending_digits[$];
   int             error_count = 0;
   int             cycle_count = 0;

   // directed table: a non-empty text is the decimal string read straight off the value,
   // an empty text means the predictor works out the digits
   logic [63:0] dir_value [DIR_N] = '{
      64'd0,                     // zero gives a lone '0'
      64'd1,
      64'd5,                     // smallest digit that takes the add-3 fixup
      64'd9,
      64'd10,
      64'd59,
      64'd99,
      64'd100,
      64'd18446744073709551615,  // all ones, twenty digits
      64'd0,                     // zero right after a full-width value: digits must clear
      64'd10000000000000000000,  // twenty digits, mostly zeros
      64'd9999999999999999999,   // nineteen nines
      64'd12345678901234567890,
      64'd4294967295,
      64'd1000000,
      64'h8000_0000_0000_0000,   // only the top bit
      64'h8000_0000_0000_0001,
      64'h5555_5555_5555_5555,
      64'hAAAA_AAAA_AAAA_AAAA,
      64'h0123_4567_89AB_CDEF
   };
   string dir_text [DIR_N] = '{
      "0", "1", "5", "9", "10", "59", "99", "100",
      "18446744073709551615", "0", "10000000000000000000", "9999999999999999999",
      "12345678901234567890", "4294967295", "1000000",
      "", "", "", "", ""
   };

   binary_to_decimal_ascii_top DUT (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_value       (req_value),
      .rsp_strobe      (rsp_strobe),
      .rsp_ascii_digit (rsp_ascii_digit),
      .rsp_last_digit  (rsp_last_digit)
   );

   always #5 clock = ~clock;

   // one line per mismatch, counted for the final verdict
   task automatic report_mismatch(input string what, input int got, input int want);
      error_count++;
      $display("[%0t] mismatch: %s got %0d expected %0d", $realtime, what, got, want);
   endtask

   // predictor: peel decimal digits off the value, queue them most significant first
   task automatic predict_digits(input logic [63:0] value);
      logic [3:0]     digit [MAX_DIGITS];
      logic [63:0]    rest;
      int             count;
      digit_beat_type beat;
      rest  = value;
      count = 0;
      // zero still yields one digit
      do begin
         digit[count] = 4'(rest % 64'd10);
         rest         = rest / 64'd10;
         count++;
      end while (rest != 0 && count < MAX_DIGITS);
      for (int i = count - 1; i >= 0; i--) begin
         beat.ascii   = ASCII_ZERO + ASCII_W'(digit[i]);
         beat.is_last = (i == 0);
         pending_digits.push_back(beat);
      end
   endtask

   // typed-in expectation: queue each character of the decimal string
   task automatic expect_text(input string text);
      digit_beat_type beat;
      byte            ch;
      for (int i = 0; i < text.len(); i++) begin
         ch           = text[i];
         beat.ascii   = ch[ASCII_W-1:0];
         beat.is_last = (i == text.len() - 1);
         pending_digits.push_back(beat);
      end
   endtask

   // drive one command beat; returns in the step where it was taken with start still high
   task automatic send_value(input logic [63:0] value, input string text);
      req_value <= value;
      start     <= 1'b1;
      // busy read here is the value before the edge, so !busy means taken at this edge
      do @(posedge clock); while (busy);
      if (text.len() > 0) begin
         expect_text(text);
      end else begin
         predict_digits(value);
      end
   endtask

   // keep the command side low until the block is free again, then for a stretch set by n
   task automatic idle_cycles(input int n);
      start <= 1'b0;
      do @(posedge clock); while (busy);
      repeat (n - 1) @(posedge clock);
   endtask

   // random values spread over every digit count, with near powers of ten mixed in
   function automatic logic [63:0] random_value();
      logic [63:0] value;
      logic [63:0] power;
      int          mode;
      mode  = $urandom_range(0, 9);
      value = {$urandom, $urandom};
      power = 64'd1;
      if (mode >= 5 && mode <= 7) begin
         value = value >> $urandom_range(0, 63);
      end else if (mode == 8) begin
         repeat ($urandom_range(0, 19)) power = power * 64'd10;
         value = power + 64'($urandom_range(0, 2)) - 64'd1;
      end else if (mode == 9) begin
         value = 64'($urandom_range(0, 20));
      end
      return value;
   endfunction

   // result side: the receiver cannot stall, so every strobe is checked at the edge ending it
   always @(posedge clock) begin
      digit_beat_type want;
      if (!reset && rsp_strobe) begin
         if (pending_digits.size() == 0) begin
            report_mismatch("unexpected digit beat, ascii", rsp_ascii_digit, -1);
         end else begin
            want = pending_digits.pop_front();
            if (rsp_ascii_digit !== want.ascii)
               report_mismatch("ascii_digit", rsp_ascii_digit, want.ascii);
            if (rsp_last_digit !== want.is_last)
               report_mismatch("last_digit", rsp_last_digit, want.is_last);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL binary_to_decimal_ascii_top");
         $finish;
      end
   end

   initial begin
      int wait_count;
      reset     = 1'b1;
      start     = 1'b0;
      req_value = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed part, mostly back to back with a gap now and then
      for (int i = 0; i < DIR_N; i++) begin
         send_value(dir_value[i], dir_text[i]);
         if (i % 7 == 6) idle_cycles($urandom_range(1, 3));
      end

      // random part
      for (int i = 0; i < RANDOM_BEATS; i++) begin
         // hold off once until every digit in flight has come out
         if (i == PAUSE_AT) begin
            start <= 1'b0;
            while (pending_digits.size() != 0) @(posedge clock);
         end
         // random idle bursts, none in the tail of the run
         if (i != PAUSE_AT && i < RANDOM_BEATS - QUIET_TAIL && $urandom_range(0, 3) == 0)
            idle_cycles($urandom_range(1, 3));
         send_value(random_value(), "");
      end
      start <= 1'b0;

      // drain: wait for the last digits, then a little longer for stray beats
      wait_count = 0;
      while (pending_digits.size() != 0 && wait_count < 20 * DRAIN_CYCLES) begin
         @(posedge clock);
         wait_count++;
      end
      if (pending_digits.size() != 0)
         report_mismatch("digit beats never seen", 0, pending_digits.size());
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("PASS binary_to_decimal_ascii_top");
      end else begin
         $display("FAIL binary_to_decimal_ascii_top");
      end
      $finish;
   end

endmodule
